@@ design/mste_pkg.sv @@
package mste_pkg;

    // field widths fixed by the item formats
    localparam int OPCODE_W   = 2;
    localparam int STEP_W     = 10;
    localparam int CLOCK_W    = 32;
    localparam int BYTE_W     = 8;
    localparam int SLOT_IDX_W = 6;

    // firings reported per tick at most, and a counter that holds it
    localparam int MAX_FIRE   = 8;
    localparam int FIRE_CNT_W = 4;

    localparam logic [STEP_W-1:0] STEP_RESET = 10'd55;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SET   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_SET_ACK = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_NO_FIRE = 2'd2;
    localparam logic [1:0] KIND_CLEARED = 2'd3;

    // output register load sources
    typedef logic [2:0] mste_osel_t;
    localparam mste_osel_t OSEL_PEND_MORE = 3'd0;
    localparam mste_osel_t OSEL_PEND_LAST = 3'd1;
    localparam mste_osel_t OSEL_NO_FIRE   = 3'd2;
    localparam mste_osel_t OSEL_SET       = 3'd3;
    localparam mste_osel_t OSEL_CLEAR     = 3'd4;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BYTE_W-1:0]   handler_id;
        logic [BYTE_W-1:0]   handler_param;
        logic [CLOCK_W-1:0]  delay_ms;
    } mste_in_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  status;
        logic [SLOT_IDX_W-1:0] slot_index;
        logic [BYTE_W-1:0]     fired_handler;
        logic [BYTE_W-1:0]     fired_param;
        logic [CLOCK_W-1:0]    now_ms;
        logic                  last;
    } mste_out_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  handler;
        logic [BYTE_W-1:0]  param;
        logic [CLOCK_W-1:0] end_ms;
    } mste_slot_t;

    typedef struct packed {
        logic       start_tick;
        logic       start_set;
        logic       clear_all;
        logic       scan_step;
        logic       find_step;
        logic       set_write;
        logic       load_out;
        mste_osel_t out_sel;
    } mste_cmd_t;

    typedef struct packed {
        logic out_free;
        logic fire;
        logic fire_limit;
        logic pend_valid;
        logic scan_done;
        logic find_hit;
        logic find_end;
    } mste_sts_t;

endpackage

@@ design/mste_datapath.sv @@
module mste_datapath
    import mste_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [STEP_W-1:0]   cfg_data,
    input  mste_in_t            in_data,
    input  mste_cmd_t           cmd,
    output mste_sts_t           sts,
    output logic                out_valid,
    input  logic                out_stall,
    output mste_out_t           out_data
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    logic [STEP_W-1:0]     step_reg;
    logic [CLOCK_W-1:0]    clock_reg;
    logic [SLOT_COUNT-1:0] active_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  eval_valid_reg;
    logic [IDX_W-1:0]      eval_idx_reg;
    logic [FIRE_CNT_W-1:0] fire_cnt_reg;
    logic                  pend_valid_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic [BYTE_W-1:0]     pend_handler_reg;
    logic [BYTE_W-1:0]     pend_param_reg;
    logic [CLOCK_W:0]      sum_reg;
    logic [BYTE_W-1:0]     set_handler_reg;
    logic [BYTE_W-1:0]     set_param_reg;
    logic                  found_reg;
    logic                  out_valid_reg;
    mste_out_t             out_data_reg;
    mste_slot_t            rd_data_reg;
    mste_slot_t            slot_mem [SLOT_COUNT];

    logic                  cnt_in_range;
    logic [IDX_W-1:0]      cnt_idx;
    logic                  fire;
    logic                  out_free;
    mste_slot_t            wr_slot;
    mste_out_t             out_load;

    assign cnt_in_range = (cnt_reg < CNT_W'(SLOT_COUNT));
    assign cnt_idx      = cnt_reg[IDX_W-1:0];
    assign fire         = eval_valid_reg && active_reg[eval_idx_reg]
                          && (rd_data_reg.end_ms <= clock_reg);
    assign out_free     = !out_valid_reg || !out_stall;

    // carry out of now+delay means wrap: end = delay - (max - now) = sum + 1
    assign wr_slot.handler = set_handler_reg;
    assign wr_slot.param   = set_param_reg;
    assign wr_slot.end_ms  = sum_reg[CLOCK_W-1:0] + CLOCK_W'(sum_reg[CLOCK_W]);

    always_comb
    begin
        sts.out_free   = out_free;
        sts.fire       = fire;
        sts.fire_limit = fire && (fire_cnt_reg == FIRE_CNT_W'(MAX_FIRE - 1));
        sts.pend_valid = pend_valid_reg;
        sts.scan_done  = !eval_valid_reg && !cnt_in_range;
        sts.find_hit   = cnt_in_range && !active_reg[cnt_idx];
        sts.find_end   = !cnt_in_range;
    end

    always_comb
    begin
        out_load        = '0;
        out_load.now_ms = clock_reg;
        out_load.last   = 1'b1;
        unique case (cmd.out_sel)
            OSEL_PEND_MORE, OSEL_PEND_LAST:
            begin
                out_load.kind          = KIND_FIRED;
                out_load.slot_index    = SLOT_IDX_W'(pend_idx_reg);
                out_load.fired_handler = pend_handler_reg;
                out_load.fired_param   = pend_param_reg;
                out_load.last          = (cmd.out_sel == OSEL_PEND_LAST);
            end
            OSEL_NO_FIRE:
            begin
                out_load.kind = KIND_NO_FIRE;
            end
            OSEL_SET:
            begin
                out_load.kind       = KIND_SET_ACK;
                out_load.status     = !found_reg;
                out_load.slot_index = found_reg ? SLOT_IDX_W'(cnt_idx) : '0;
            end
            OSEL_CLEAR:
            begin
                out_load.kind = KIND_CLEARED;
            end
            default:
            begin
                out_load.kind = KIND_CLEARED;
            end
        endcase
    end

    // slot store: one write port for set, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (cmd.set_write)
        begin
            slot_mem[cnt_idx] <= wr_slot;
        end
        if (cmd.scan_step && cnt_in_range)
        begin
            rd_data_reg <= slot_mem[cnt_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_RESET;
            clock_reg      <= '0;
            active_reg     <= '0;
            cnt_reg        <= '0;
            eval_valid_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                step_reg <= cfg_data;
            end

            if (cmd.start_tick)
            begin
                clock_reg      <= clock_reg + CLOCK_W'(step_reg);
                cnt_reg        <= '0;
                eval_valid_reg <= 1'b0;
                fire_cnt_reg   <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.start_set)
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                eval_valid_reg <= cnt_in_range;
                if (cnt_in_range)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (fire)
                begin
                    pend_valid_reg <= 1'b1;
                    fire_cnt_reg   <= fire_cnt_reg + 1'b1;
                end
            end
            else if (cmd.find_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.set_write)
            begin
                found_reg <= 1'b1;
            end

            priority if (cmd.clear_all)
            begin
                active_reg <= '0;
            end
            else if (cmd.scan_step && fire)
            begin
                active_reg[eval_idx_reg] <= 1'b0;
            end
            else if (cmd.set_write)
            begin
                active_reg[cnt_idx] <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_set)
        begin
            sum_reg         <= {1'b0, clock_reg} + {1'b0, in_data.delay_ms};
            set_handler_reg <= in_data.handler_id;
            set_param_reg   <= in_data.handler_param;
        end
        if (cmd.scan_step)
        begin
            eval_idx_reg <= cnt_idx;
            if (fire)
            begin
                pend_idx_reg     <= eval_idx_reg;
                pend_handler_reg <= rd_data_reg.handler;
                pend_param_reg   <= rd_data_reg.param;
            end
        end
        if (cmd.load_out)
        begin
            out_data_reg <= out_load;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ design/mste_ctrl.sv @@
module mste_ctrl
    import mste_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OPCODE_W-1:0] in_opcode,
    input  mste_sts_t           sts,
    output mste_cmd_t           cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_FLUSH   = 3'd2;
    localparam logic [2:0] S_FIND    = 3'd3;
    localparam logic [2:0] S_SET_ACK = 3'd4;
    localparam logic [2:0] S_CLR_ACK = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;
    logic       hold;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    // a second firing needs the held one moved out first
    assign hold     = sts.fire && sts.pend_valid && !sts.out_free;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_opcode == OP_TICK)
                    begin
                        cmd.start_tick = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else if (in_opcode == OP_SET)
                    begin
                        cmd.start_set = 1'b1;
                        state_next    = S_FIND;
                    end
                    else if (in_opcode == OP_CLEAR)
                    begin
                        cmd.clear_all = 1'b1;
                        state_next    = S_CLR_ACK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_FLUSH;
                end
                else if (!hold)
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.fire && sts.pend_valid)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = OSEL_PEND_MORE;
                    end
                    if (sts.fire_limit)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = sts.pend_valid ? OSEL_PEND_LAST : OSEL_NO_FIRE;
                    state_next   = S_IDLE;
                end
            end
            S_FIND:
            begin
                priority if (sts.find_hit)
                begin
                    cmd.set_write = 1'b1;
                    state_next    = S_SET_ACK;
                end
                else if (sts.find_end)
                begin
                    state_next = S_SET_ACK;
                end
                else
                begin
                    cmd.find_step = 1'b1;
                end
            end
            S_SET_ACK:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OSEL_SET;
                    state_next   = S_IDLE;
                end
            end
            S_CLR_ACK:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = OSEL_CLEAR;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ design/multi_slot_timeout_engine.sv @@
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall   | in_data  (mste_in_t: opcode, handler, param, delay)
// out     | output    | out_valid / out_stall | out_data (mste_out_t: one or more results per request)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (tick_step, milliseconds per tick)
//
// a tick walks the slot store one slot a cycle through its single registered read port,
// held while a second firing waits on a stalled output; the firing cap can end it early
// a set walks the active bits one slot a cycle until it finds a free slot or the end
// requests are taken only between items; the output register lets the next request in
// while the final result of the last one still waits
// reset clears the clock, all active bits and the output valid; tick_step resets to 55
module multi_slot_timeout_engine
    import mste_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mste_in_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output mste_out_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [STEP_W-1:0] cfg_data
);

    mste_cmd_t cmd;
    mste_sts_t sts;

    // the step register takes a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: decodes the request, steps the scans and orders the results
    mste_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_opcode (in_data.opcode),
        .sts       (sts),
        .cmd       (cmd)
    );

    // clock, slot store, expiry compare, held firing and output register
    mste_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ design/mste_checker.sv @@
module mste_checker
    import mste_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input mste_in_t          in_data,
    input logic              out_valid,
    input logic              out_stall,
    input mste_out_t         out_data
);

    // held result does not change while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // only firings can be followed by more results of the same request
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != KIND_FIRED) |-> out_data.last)
        else $error("non-firing result without last");

    // a full table reports no slot
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |->
            (out_data.kind == KIND_SET_ACK) && (out_data.slot_index == '0))
        else $error("bad full status");

    // handler and parameter only travel with a firing
    a_fired_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != KIND_FIRED) |->
            (out_data.fired_handler == '0) && (out_data.fired_param == '0))
        else $error("handler data on a non-firing result");

    // a tick always keeps the input busy while its scan runs
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.opcode == OP_TICK) |=> in_stall)
        else $error("request taken during a scan");

endmodule

bind multi_slot_timeout_engine mste_checker u_mste_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
